// File: rtl/core/hmsvr_pkg.sv
`timescale 1ns / 1ps

package hmsvr_pkg;

    localparam int CORDIC_ITERS_DEF = 16;
    localparam int CORDIC_MAX       = 24;
    localparam int CNT_W            = 5;

    localparam int XY_W  = 36;
    localparam int Z_W   = 28;
    localparam int POS_W = 32;
    localparam int VEL_W = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int ANG_W  = 15;
    localparam int DIST_W = 31;
    localparam int SPD_W  = 15;
    localparam int STEP_W = 14;

    localparam logic [ANG_W-1:0]  SAFETY_ANGLE_RST = ANG_W'(819);
    localparam logic [DIST_W-1:0] SAFETY_DIST_RST  = DIST_W'(0);
    localparam logic [SPD_W-1:0]  MAX_LIN_RST      = SPD_W'(819);
    localparam logic [SPD_W-1:0]  MAX_TURN_RST     = SPD_W'(6144);
    localparam logic [STEP_W-1:0] RAMP_STEP_RST    = STEP_W'(205);

    localparam logic signed [POS_W-1:0] Y_DEADBAND  = POS_W'(65);
    localparam logic signed [Z_W-1:0]   HALF_PI_Q24 = Z_W'(26353589);
    localparam logic signed [Z_W:0]     PI_Q13      = (Z_W+1)'(25736);
    localparam logic signed [Z_W:0]     ROUND_HALF  = (Z_W+1)'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAFETY_ANGLE = 3'd0,
        CFG_SAFETY_DIST  = 3'd1,
        CFG_MAX_LIN      = 3'd2,
        CFG_MAX_TURN     = 3'd3,
        CFG_RAMP_STEP    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_LEFT  = 2'd2,
        MODE_FWD   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_CORDIC = 2'd1,
        ST_DECIDE = 2'd2,
        ST_TICK   = 2'd3
    } t_state;

    typedef struct packed {
        logic load_target;
        logic iter;
        logic decide;
        logic tick;
    } t_cmd;

    typedef struct packed {
        logic last_iter;
        logic out_free;
    } t_status;

    function automatic logic signed [Z_W-1:0] atan_q24(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd13176795;
            5'd1:  v = 32'd7778716;
            5'd2:  v = 32'd4110060;
            5'd3:  v = 32'd2086331;
            5'd4:  v = 32'd1047214;
            5'd5:  v = 32'd524117;
            5'd6:  v = 32'd262123;
            5'd7:  v = 32'd131069;
            5'd8:  v = 32'd65536;
            5'd9:  v = 32'd32768;
            5'd10: v = 32'd16384;
            5'd11: v = 32'd8192;
            5'd12: v = 32'd4096;
            5'd13: v = 32'd2048;
            5'd14: v = 32'd1024;
            5'd15: v = 32'd512;
            5'd16: v = 32'd256;
            5'd17: v = 32'd128;
            5'd18: v = 32'd64;
            5'd19: v = 32'd32;
            5'd20: v = 32'd16;
            5'd21: v = 32'd8;
            5'd22: v = 32'd4;
            5'd23: v = 32'd2;
            default: v = 32'd0;
        endcase
        return v[Z_W-1:0];
    endfunction

endpackage

// File: rtl/core/hmsvr_ctrl.sv
`timescale 1ns / 1ps

module hmsvr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_func,
    output logic              o_ready,
    input  hmsvr_pkg::t_status i_status,
    output hmsvr_pkg::t_cmd   o_cmd
);
    import hmsvr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_func) begin
                        n_state = ST_TICK;
                    end else begin
                        o_cmd.load_target = 1'b1;
                        n_state           = ST_CORDIC;
                    end
                end
            end
            ST_CORDIC: begin
                o_cmd.iter = 1'b1;
                if (i_status.last_iter) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_TICK: begin
                if (i_status.out_free) begin
                    o_cmd.tick = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_target, o_cmd.iter, o_cmd.decide, o_cmd.tick}))
        else $error("more than one datapath command");

    a_decide_after_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> ($past(r_state) == ST_CORDIC))
        else $error("decide without cordic");

endmodule

// File: rtl/core/hmsvr_dp.sv
`timescale 1ns / 1ps

module hmsvr_dp #(
    parameter int CORDIC_ITERS = hmsvr_pkg::CORDIC_ITERS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hmsvr_pkg::t_cmd                      i_cmd,
    output hmsvr_pkg::t_status                   o_status,
    input  logic                                 i_cfg_valid,
    input  logic [hmsvr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hmsvr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [hmsvr_pkg::POS_W-1:0]   i_target_x,
    input  logic signed [hmsvr_pkg::POS_W-1:0]   i_target_y,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [hmsvr_pkg::VEL_W-1:0]   o_linear_speed,
    output logic signed [hmsvr_pkg::VEL_W-1:0]   o_turn_rate,
    output logic [1:0]                           o_mode
);
    import hmsvr_pkg::*;

    localparam int N_ITER = (CORDIC_ITERS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_ITERS;

    logic [ANG_W-1:0]  r_safety_angle;
    logic [DIST_W-1:0] r_safety_dist;
    logic [SPD_W-1:0]  r_max_lin;
    logic [SPD_W-1:0]  r_max_turn;
    logic [STEP_W-1:0] r_ramp_step;

    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [CNT_W-1:0]        r_iter;
    logic                    r_dead;
    logic signed [POS_W-1:0] r_tx;

    t_mode                   r_mode;
    t_mode                   r_out_mode;
    logic                    r_out_valid;
    logic signed [VEL_W-1:0] r_lin;
    logic signed [VEL_W-1:0] r_turn;

    // cfg writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safety_angle <= SAFETY_ANGLE_RST;
            r_safety_dist  <= SAFETY_DIST_RST;
            r_max_lin      <= MAX_LIN_RST;
            r_max_turn     <= MAX_TURN_RST;
            r_ramp_step    <= RAMP_STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SAFETY_ANGLE: r_safety_angle <= i_cfg_data[ANG_W-1:0];
                CFG_SAFETY_DIST:  r_safety_dist  <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_LIN:      r_max_lin      <= i_cfg_data[SPD_W-1:0];
                CFG_MAX_TURN:     r_max_turn     <= i_cfg_data[SPD_W-1:0];
                CFG_RAMP_STEP:    r_ramp_step    <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // CORDIC vectoring
    logic signed [XY_W-1:0] w_x0;
    logic signed [XY_W-1:0] w_y0;
    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;
    logic signed [Z_W-1:0]  w_atan;

    assign w_x0   = XY_W'(i_target_x);
    assign w_y0   = XY_W'(i_target_y);
    assign w_xs   = r_x >>> r_iter;
    assign w_ys   = r_y >>> r_iter;
    assign w_atan = atan_q24(r_iter);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_target) begin
            r_tx   <= i_target_x;
            r_dead <= (i_target_y <= Y_DEADBAND) && (i_target_y >= -Y_DEADBAND);
            r_iter <= '0;
            if (i_target_x < 0) begin
                if (i_target_y >= 0) begin
                    r_x <= w_y0;
                    r_y <= -w_x0;
                    r_z <= HALF_PI_Q24;
                end else begin
                    r_x <= -w_y0;
                    r_y <= w_x0;
                    r_z <= -HALF_PI_Q24;
                end
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end else if (i_cmd.iter) begin
            r_iter <= r_iter + CNT_W'(1);
            if (r_y > 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
        end
    end

    // heading rounding and mode select
    logic signed [Z_W:0]   w_zr;
    logic signed [Z_W:0]   w_sat;
    logic signed [ANG_W+1:0] w_head;
    logic signed [ANG_W+1:0] w_sa;
    t_mode                 w_new_mode;

    assign w_zr = ((Z_W+1)'(r_z) + ROUND_HALF) >>> 11;

    always_comb begin
        if (w_zr > PI_Q13) begin
            w_sat = PI_Q13;
        end else if (w_zr < -PI_Q13) begin
            w_sat = -PI_Q13;
        end else begin
            w_sat = w_zr;
        end
        w_head = r_dead ? '0 : w_sat[ANG_W+1:0];
        w_sa   = $signed({2'b00, r_safety_angle});
        if (w_head > w_sa) begin
            w_new_mode = MODE_LEFT;
        end else if (w_head < -w_sa) begin
            w_new_mode = MODE_RIGHT;
        end else if ($signed({r_tx[POS_W-1], r_tx}) > $signed({2'b00, r_safety_dist})) begin
            w_new_mode = MODE_FWD;
        end else begin
            w_new_mode = MODE_STOP;
        end
    end

    // velocity ramp
    function automatic logic signed [VEL_W-1:0] ramp(
        input logic signed [VEL_W-1:0] cur,
        input logic signed [VEL_W-1:0] tgt,
        input logic [STEP_W-1:0]       step
    );
        logic signed [VEL_W+1:0] d;
        logic [VEL_W+1:0]        a;
        logic [VEL_W+2:0]        lim;
        logic signed [VEL_W+1:0] s;
        d   = (VEL_W+2)'(cur) - (VEL_W+2)'(tgt);
        a   = d[VEL_W+1] ? (VEL_W+2)'(-d) : d;
        lim = (VEL_W+3)'(step) * (VEL_W+3)'(3);
        s   = $signed((VEL_W+2)'(step));
        if ({a, 1'b0} > lim) begin
            return (d > 0) ? VEL_W'((VEL_W+2)'(cur) - s) : VEL_W'((VEL_W+2)'(cur) + s);
        end
        return tgt;
    endfunction

    logic signed [VEL_W-1:0] w_lin_tgt;
    logic signed [VEL_W-1:0] w_turn_pos;
    logic signed [VEL_W-1:0] w_turn_neg;

    assign w_lin_tgt  = $signed({1'b0, r_max_lin});
    assign w_turn_pos = $signed({1'b0, r_max_turn});
    assign w_turn_neg = -w_turn_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STOP;
            r_lin       <= '0;
            r_turn      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                r_mode <= w_new_mode;
            end
            if (i_cmd.tick) begin
                r_out_valid <= 1'b1;
                case (r_mode)
                    MODE_RIGHT: begin
                        r_turn <= ramp(r_turn, w_turn_neg, r_ramp_step);
                        r_lin  <= '0;
                    end
                    MODE_LEFT: begin
                        r_turn <= ramp(r_turn, w_turn_pos, r_ramp_step);
                        r_lin  <= '0;
                    end
                    MODE_FWD: begin
                        r_lin  <= ramp(r_lin, w_lin_tgt, r_ramp_step);
                        r_turn <= '0;
                    end
                    default: begin
                        r_lin  <= '0;
                        r_turn <= '0;
                    end
                endcase
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_out_mode <= r_mode;
        end
    end

    assign o_status.last_iter = (r_iter == CNT_W'(N_ITER - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_linear_speed = r_lin;
    assign o_turn_rate    = r_turn;
    assign o_mode         = r_out_mode;

    a_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lin != 0) |-> (r_turn == 0))
        else $error("linear and angular speed both nonzero");

    a_lin_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lin[VEL_W-1])
        else $error("linear speed went negative");

endmodule

// File: rtl/core/heading_mode_select_with_velocity_ramp.sv
`timescale 1ns / 1ps
// Heading mode select with velocity ramp.
// Input channel (i_valid / o_ready) carries one item: i_func = 0 is a target
// point (i_target_x, i_target_y, Q16.16), i_func = 1 is a control tick.
// A target item produces no output; it runs a CORDIC of CORDIC_ITERS steps
// (at most 24; one iteration per cycle on a shared shift-add unit) and
// updates the motion mode. The input stays busy until the mode is updated.
// A tick item steps the velocities and yields one item on the output channel
// (o_valid / i_ready): o_linear_speed, o_turn_rate (Q4.12) and o_mode.
// The tick waits in a tick state until the output slot is free, then loads
// the output register; the input is ready again at that point.
// The output item sits in a register: while the receiver stalls, target
// items are still taken; a following tick waits until the slot frees.
// Config writes (i_cfg_valid / o_cfg_ready, always ready) set the five
// registers by index; other indexes are ignored. Write only while idle.
// Synchronous reset: cfg defaults, mode stop, zero speeds; o_mode not reset.
module heading_mode_select_with_velocity_ramp #(
    parameter int CORDIC_ITERS = hmsvr_pkg::CORDIC_ITERS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_func,
    input  logic signed [hmsvr_pkg::POS_W-1:0]   i_target_x,
    input  logic signed [hmsvr_pkg::POS_W-1:0]   i_target_y,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [hmsvr_pkg::VEL_W-1:0]   o_linear_speed,
    output logic signed [hmsvr_pkg::VEL_W-1:0]   o_turn_rate,
    output logic [1:0]                           o_mode,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hmsvr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hmsvr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import hmsvr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    hmsvr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    hmsvr_dp #(
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_linear_speed (o_linear_speed),
        .o_turn_rate    (o_turn_rate),
        .o_mode         (o_mode)
    );

endmodule
